// ===== sv/erpd_pkg.sv =====
`timescale 1ns / 1ps
package erpd_pkg;

  // cordic geometry, Q.32 datapath with headroom
  localparam int CORDIC_STEPS    = 32;
  localparam int STEPS_PER_STAGE = 4;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int XY_W            = 35;
  localparam int Z_W             = 33;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 35'sd2608131496;

  localparam int NUM_LANES   = 3;
  localparam int NUM_TRIG    = 6;
  localparam int NUM_ENTRIES = 9;

  // selector codes
  localparam logic [1:0] FUNC_PHI   = 2'd0;
  localparam logic [1:0] FUNC_THETA = 2'd1;
  localparam logic [1:0] FUNC_PSI   = 2'd2;

  // factor codes; trig factors map onto trig index code - FAC_SF
  typedef enum logic [2:0] {
    FAC_ZERO, FAC_ONE, FAC_SF, FAC_CF, FAC_ST, FAC_CT, FAC_SP, FAC_CP
  } fac_t;

  // one entry: +-(a*b) +- ((d*e)*g)
  typedef struct packed {
    fac_t a;
    fac_t b;
    logic neg_p;
    fac_t d;
    fac_t e;
    fac_t g;
    logic neg_t;
  } term_sel_t;

  // arctangent table in units of 2^-32 turn
  function automatic logic signed [Z_W-1:0] atan_turn(input int idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      0:  v = 33'sh020000000;
      1:  v = 33'sh012E4051E;
      2:  v = 33'sh009FB385B;
      3:  v = 33'sh0051111D4;
      4:  v = 33'sh0028B0D43;
      5:  v = 33'sh00145D7E1;
      6:  v = 33'sh000A2F61E;
      7:  v = 33'sh000517C55;
      8:  v = 33'sh00028BE53;
      9:  v = 33'sh000145F2F;
      10: v = 33'sh0000A2F98;
      11: v = 33'sh0000517CC;
      12: v = 33'sh000028BE6;
      13: v = 33'sh0000145F3;
      14: v = 33'sh00000A2FA;
      15: v = 33'sh00000517D;
      16: v = 33'sh0000028BE;
      17: v = 33'sh00000145F;
      18: v = 33'sh000000A30;
      19: v = 33'sh000000518;
      20: v = 33'sh00000028C;
      21: v = 33'sh000000146;
      22: v = 33'sh0000000A3;
      23: v = 33'sh000000051;
      24: v = 33'sh000000029;
      25: v = 33'sh000000014;
      26: v = 33'sh00000000A;
      27: v = 33'sh000000005;
      28: v = 33'sh000000003;
      29: v = 33'sh000000001;
      30: v = 33'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic term_sel_t mk(input fac_t a, input fac_t b, input logic np,
                                   input fac_t d, input fac_t e, input fac_t g,
                                   input logic nt);
    term_sel_t t;
    t.a = a; t.b = b; t.neg_p = np;
    t.d = d; t.e = e; t.g = g; t.neg_t = nt;
    return t;
  endfunction

  // term selection for each selector and entry, row-major
  function automatic term_sel_t term_sel(input logic [1:0] func, input logic [3:0] entry);
    term_sel_t t;
    t = mk(FAC_ZERO, FAC_ZERO, 1'b0, FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0);
    case (func)
      FUNC_PHI: begin
        case (entry)
          4'd0: t = mk(FAC_CT, FAC_SF, 1'b1, FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0);
          4'd1: t = mk(FAC_CT, FAC_CF, 1'b1, FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0);
          4'd3: t = mk(FAC_CP, FAC_CF, 1'b0, FAC_ST, FAC_SP, FAC_SF, 1'b1);
          4'd4: t = mk(FAC_CP, FAC_SF, 1'b1, FAC_ST, FAC_CF, FAC_SP, 1'b1);
          4'd6: t = mk(FAC_SP, FAC_CF, 1'b0, FAC_ST, FAC_SF, FAC_CP, 1'b0);
          4'd7: t = mk(FAC_SP, FAC_SF, 1'b1, FAC_ST, FAC_CF, FAC_CP, 1'b0);
          default: ;
        endcase
      end
      FUNC_THETA: begin
        case (entry)
          4'd0: t = mk(FAC_ST, FAC_CF, 1'b1, FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0);
          4'd1: t = mk(FAC_ST, FAC_SF, 1'b0, FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0);
          4'd2: t = mk(FAC_CT, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0);
          4'd3: t = mk(FAC_ZERO, FAC_ZERO, 1'b0, FAC_CT, FAC_SP, FAC_CF, 1'b0);
          4'd4: t = mk(FAC_ZERO, FAC_ZERO, 1'b0, FAC_CT, FAC_SF, FAC_SP, 1'b1);
          4'd5: t = mk(FAC_SP, FAC_ST, 1'b0, FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0);
          4'd6: t = mk(FAC_ZERO, FAC_ZERO, 1'b0, FAC_CT, FAC_CF, FAC_CP, 1'b1);
          4'd7: t = mk(FAC_ZERO, FAC_ZERO, 1'b0, FAC_CT, FAC_SF, FAC_CP, 1'b0);
          4'd8: t = mk(FAC_ST, FAC_CP, 1'b1, FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0);
          default: ;
        endcase
      end
      FUNC_PSI: begin
        case (entry)
          4'd3: t = mk(FAC_SP, FAC_SF, 1'b1, FAC_ST, FAC_CP, FAC_CF, 1'b0);
          4'd4: t = mk(FAC_SP, FAC_CF, 1'b1, FAC_ST, FAC_SF, FAC_CP, 1'b1);
          4'd5: t = mk(FAC_CP, FAC_CT, 1'b1, FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0);
          4'd6: t = mk(FAC_CP, FAC_SF, 1'b0, FAC_ST, FAC_CF, FAC_SP, 1'b0);
          4'd7: t = mk(FAC_CP, FAC_CF, 1'b0, FAC_ST, FAC_SF, FAC_SP, 1'b1);
          4'd8: t = mk(FAC_CT, FAC_SP, 1'b1, FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0);
          default: ;
        endcase
      end
      default: ;
    endcase
    return t;
  endfunction

endpackage

// ===== sv/erpd_cordic.sv =====
`timescale 1ns / 1ps
module erpd_cordic import erpd_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [ANGLE_BITS-1:0]       in_angle [NUM_LANES],
  output logic                        trig_valid,
  input  logic                        trig_ready,
  output logic [1:0]                  trig_func,
  output logic signed [FRAC_BITS+1:0] trig [NUM_TRIG]
);

  localparam int W = FRAC_BITS + 2;
  localparam int LAST = CORDIC_STAGES - 1;
  localparam logic signed [XY_W-1:0] RND    = XY_W'(1) << (31 - FRAC_BITS);
  localparam logic signed [XY_W-1:0] ONE_XY = XY_W'(1) << FRAC_BITS;

  logic signed [XY_W-1:0] x_r   [CORDIC_STAGES][NUM_LANES];
  logic signed [XY_W-1:0] y_r   [CORDIC_STAGES][NUM_LANES];
  logic signed [Z_W-1:0]  z_r   [CORDIC_STAGES][NUM_LANES];
  logic [1:0]             quad_r[CORDIC_STAGES][NUM_LANES];
  logic [1:0]             func_r[CORDIC_STAGES];
  logic                   v_r   [CORDIC_STAGES];

  logic signed [XY_W-1:0] x_in  [CORDIC_STAGES][NUM_LANES];
  logic signed [XY_W-1:0] y_in  [CORDIC_STAGES][NUM_LANES];
  logic signed [Z_W-1:0]  z_in  [CORDIC_STAGES][NUM_LANES];
  logic [1:0]             quad_in[CORDIC_STAGES][NUM_LANES];
  logic [1:0]             func_in[CORDIC_STAGES];
  logic                   v_in  [CORDIC_STAGES];

  logic signed [XY_W-1:0] x_nxt [CORDIC_STAGES][NUM_LANES];
  logic signed [XY_W-1:0] y_nxt [CORDIC_STAGES][NUM_LANES];
  logic signed [Z_W-1:0]  z_nxt [CORDIC_STAGES][NUM_LANES];

  logic [CORDIC_STAGES:0] en;

  logic signed [W-1:0] trig_r   [NUM_TRIG];
  logic signed [W-1:0] trig_nxt [NUM_TRIG];
  logic [1:0]          trig_func_r;
  logic                trig_v_r;

  // stage advance chain, a stage loads when empty or when it drains
  assign en[CORDIC_STAGES] = !trig_v_r || trig_ready;
  assign in_ready = en[0];

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    assign en[s] = !v_r[s] || en[s+1];

    // stage inputs: seed from the request or the previous stage
    if (s == 0) begin : g_seed
      logic [31:0] ang32 [NUM_LANES];
      for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        assign ang32[l]      = {in_angle[l], {(32 - ANGLE_BITS){1'b0}}};
        assign x_in[s][l]    = CORDIC_GAIN;
        assign y_in[s][l]    = '0;
        assign z_in[s][l]    = {3'b000, ang32[l][29:0]};
        assign quad_in[s][l] = ang32[l][31:30];
      end
      assign func_in[s] = in_func;
      assign v_in[s]    = in_valid;
    end else begin : g_chain
      for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        assign x_in[s][l]    = x_r[s-1][l];
        assign y_in[s][l]    = y_r[s-1][l];
        assign z_in[s][l]    = z_r[s-1][l];
        assign quad_in[s][l] = quad_r[s-1][l];
      end
      assign func_in[s] = func_r[s-1];
      assign v_in[s]    = v_r[s-1];
    end

    // four micro-rotations per stage
    always_comb begin
      logic signed [XY_W-1:0] xa, ya, xt;
      logic signed [Z_W-1:0]  za;
      for (int l = 0; l < NUM_LANES; l++) begin
        xa = x_in[s][l];
        ya = y_in[s][l];
        za = z_in[s][l];
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
          if (!za[Z_W-1]) begin
            xt = xa - (ya >>> (s * STEPS_PER_STAGE + k));
            ya = ya + (xa >>> (s * STEPS_PER_STAGE + k));
            za = za - atan_turn(s * STEPS_PER_STAGE + k);
          end else begin
            xt = xa + (ya >>> (s * STEPS_PER_STAGE + k));
            ya = ya - (xa >>> (s * STEPS_PER_STAGE + k));
            za = za + atan_turn(s * STEPS_PER_STAGE + k);
          end
          xa = xt;
        end
        x_nxt[s][l] = xa;
        y_nxt[s][l] = ya;
        z_nxt[s][l] = za;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= v_in[s];
      end
      if (en[s]) begin
        func_r[s] <= func_in[s];
        for (int l = 0; l < NUM_LANES; l++) begin
          x_r[s][l]    <= x_nxt[s][l];
          y_r[s][l]    <= y_nxt[s][l];
          z_r[s][l]    <= z_nxt[s][l];
          quad_r[s][l] <= quad_in[s][l];
        end
      end
    end
  end

  // round to frac bits, clamp, unfold quadrant
  always_comb begin
    logic signed [XY_W-1:0] cx, sx;
    logic signed [W-1:0]    c, s;
    for (int l = 0; l < NUM_LANES; l++) begin
      cx = (x_r[LAST][l] + RND) >>> (32 - FRAC_BITS);
      sx = (y_r[LAST][l] + RND) >>> (32 - FRAC_BITS);
      if (cx > ONE_XY) cx = ONE_XY;
      else if (cx < -ONE_XY) cx = -ONE_XY;
      if (sx > ONE_XY) sx = ONE_XY;
      else if (sx < -ONE_XY) sx = -ONE_XY;
      c = cx[W-1:0];
      s = sx[W-1:0];
      case (quad_r[LAST][l])
        2'd0: begin trig_nxt[2*l] = s;  trig_nxt[2*l+1] = c;  end
        2'd1: begin trig_nxt[2*l] = c;  trig_nxt[2*l+1] = -s; end
        2'd2: begin trig_nxt[2*l] = -s; trig_nxt[2*l+1] = -c; end
        default: begin trig_nxt[2*l] = -c; trig_nxt[2*l+1] = s; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_v_r <= 1'b0;
    end else if (en[CORDIC_STAGES]) begin
      trig_v_r <= v_r[LAST];
    end
    if (en[CORDIC_STAGES]) begin
      trig_func_r <= func_r[LAST];
      for (int t = 0; t < NUM_TRIG; t++) trig_r[t] <= trig_nxt[t];
    end
  end

  assign trig_valid = trig_v_r;
  assign trig_func  = trig_func_r;
  assign trig       = trig_r;

  // a held item in the last rotation stage stays put
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] && !en[CORDIC_STAGES] |=> v_r[LAST])
    else $error("cordic last stage dropped a stalled request");

  // a stalled trig output keeps its valid and selector
  a_trig_hold: assert property (@(posedge clk) disable iff (!rst_n)
    trig_v_r && !trig_ready |=> trig_v_r && $stable(trig_func_r))
    else $error("trig output changed while stalled");

  // sines and cosines never exceed one
  for (genvar t = 0; t < NUM_TRIG; t++) begin : g_chk
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
      trig_v_r |-> (trig_r[t] <= $signed(ONE_XY[W-1:0])) &&
                   (trig_r[t] >= -$signed(ONE_XY[W-1:0])))
      else $error("trig value out of unit range");
  end

endmodule

// ===== sv/erpd_matrix.sv =====
`timescale 1ns / 1ps
module erpd_matrix import erpd_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        trig_valid,
  output logic                        trig_ready,
  input  logic [1:0]                  trig_func,
  input  logic signed [FRAC_BITS+1:0] trig [NUM_TRIG],
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+1:0] out_m [NUM_ENTRIES]
);

  localparam int W = FRAC_BITS + 2;
  localparam logic signed [2*W-1:0] HALF  = (2*W)'(1) << (FRAC_BITS - 1);
  localparam logic signed [W-1:0]   ONE_W = W'(1) << FRAC_BITS;
  localparam logic signed [W:0]     ONE_S = (W+1)'(1) << FRAC_BITS;

  // product rounded to frac bits, add half then floor
  function automatic logic signed [W-1:0] fround(input logic signed [2*W-1:0] p);
    logic signed [2*W-1:0] r;
    r = (p + HALF) >>> FRAC_BITS;
    return r[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] pick(input fac_t f,
                                               input logic signed [W-1:0] tv [NUM_TRIG]);
    logic signed [W-1:0] v;
    case (f)
      FAC_ZERO: v = '0;
      FAC_ONE:  v = ONE_W;
      FAC_SF:   v = tv[0];
      FAC_CF:   v = tv[1];
      FAC_ST:   v = tv[2];
      FAC_CT:   v = tv[3];
      FAC_SP:   v = tv[4];
      default:  v = tv[5];
    endcase
    return v;
  endfunction

  logic signed [W-1:0] pab_r [NUM_ENTRIES], pab_nxt [NUM_ENTRIES];
  logic signed [W-1:0] de_r  [NUM_ENTRIES], de_nxt  [NUM_ENTRIES];
  logic signed [W-1:0] g_r   [NUM_ENTRIES], g_nxt   [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] negp_b_r, negt_b_r, negp_nxt, negt_nxt;
  logic vb_r;

  logic signed [W-1:0] p_r [NUM_ENTRIES];
  logic signed [W-1:0] t_r [NUM_ENTRIES], t_nxt [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] negp_c_r, negt_c_r;
  logic vc_r;

  logic signed [W-1:0] m_r [NUM_ENTRIES], m_nxt [NUM_ENTRIES];
  logic vd_r;

  logic en_b, en_c, en_d;

  assign en_d = !vd_r || out_ready;
  assign en_c = !vc_r || en_d;
  assign en_b = !vb_r || en_c;
  assign trig_ready = en_b;

  // operand select per entry, first products
  always_comb begin
    term_sel_t sel;
    logic signed [2*W-1:0] pab, pde;
    for (int j = 0; j < NUM_ENTRIES; j++) begin
      sel = term_sel(trig_func, 4'(j));
      pab = pick(sel.a, trig) * pick(sel.b, trig);
      pde = pick(sel.d, trig) * pick(sel.e, trig);
      pab_nxt[j]  = fround(pab);
      de_nxt[j]   = fround(pde);
      g_nxt[j]    = pick(sel.g, trig);
      negp_nxt[j] = sel.neg_p;
      negt_nxt[j] = sel.neg_t;
    end
  end

  // third factor of the triple products
  always_comb begin
    logic signed [2*W-1:0] pt;
    for (int j = 0; j < NUM_ENTRIES; j++) begin
      pt = de_r[j] * g_r[j];
      t_nxt[j] = fround(pt);
    end
  end

  // signed sum and saturation to plus or minus one
  always_comb begin
    logic signed [W:0] ps, ts, sum;
    for (int j = 0; j < NUM_ENTRIES; j++) begin
      ps = {p_r[j][W-1], p_r[j]};
      ts = {t_r[j][W-1], t_r[j]};
      sum = (negp_c_r[j] ? -ps : ps) + (negt_c_r[j] ? -ts : ts);
      if (sum > ONE_S) sum = ONE_S;
      else if (sum < -ONE_S) sum = -ONE_S;
      m_nxt[j] = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (en_b) vb_r <= trig_valid;
      if (en_c) vc_r <= vb_r;
      if (en_d) vd_r <= vc_r;
    end
    if (en_b) begin
      pab_r    <= pab_nxt;
      de_r     <= de_nxt;
      g_r      <= g_nxt;
      negp_b_r <= negp_nxt;
      negt_b_r <= negt_nxt;
    end
    if (en_c) begin
      p_r      <= pab_r;
      t_r      <= t_nxt;
      negp_c_r <= negp_b_r;
      negt_c_r <= negt_b_r;
    end
    if (en_d) begin
      m_r <= m_nxt;
    end
  end

  assign out_valid = vd_r;
  assign out_m     = m_r;

  // stalled items in the multiply stages are kept
  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && !en_c |=> vb_r)
    else $error("product stage dropped a stalled request");

  a_c_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r && !en_d |=> vc_r)
    else $error("triple stage dropped a stalled request");

  // every entry is saturated
  for (genvar j = 0; j < NUM_ENTRIES; j++) begin : g_chk
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
      vd_r |-> (m_r[j] <= ONE_W) && (m_r[j] >= -ONE_W))
      else $error("matrix entry beyond unit range");
  end

endmodule

// ===== sv/euler_rotation_partial_derivative.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake             | payload
// in_      | input     | in_valid / in_ready   | func, phi/theta/psi angle
// out_     | output    | out_valid / out_ready | row0_col0 .. row2_col2, Q1.14
//
// one request per cycle sustained while out_ready stays high
// the pipeline is the 32 cordic rotations, four per stage (8 stages), then
// one trig rounding stage and three multiply/sum stages
// synchronous active-low reset clears every stage valid; payload is not reset
// a stage holds while the next is full and not draining, empty stages fill
module euler_rotation_partial_derivative import erpd_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [ANGLE_BITS-1:0]       in_phi_angle,
  input  logic [ANGLE_BITS-1:0]       in_theta_angle,
  input  logic [ANGLE_BITS-1:0]       in_psi_angle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+1:0] out_row0_col0,
  output logic signed [FRAC_BITS+1:0] out_row0_col1,
  output logic signed [FRAC_BITS+1:0] out_row0_col2,
  output logic signed [FRAC_BITS+1:0] out_row1_col0,
  output logic signed [FRAC_BITS+1:0] out_row1_col1,
  output logic signed [FRAC_BITS+1:0] out_row1_col2,
  output logic signed [FRAC_BITS+1:0] out_row2_col0,
  output logic signed [FRAC_BITS+1:0] out_row2_col1,
  output logic signed [FRAC_BITS+1:0] out_row2_col2
);

  logic [ANGLE_BITS-1:0]       angle [NUM_LANES];
  logic                        trig_valid, trig_ready;
  logic [1:0]                  trig_func;
  logic signed [FRAC_BITS+1:0] trig [NUM_TRIG];
  logic signed [FRAC_BITS+1:0] m [NUM_ENTRIES];

  assign angle[0] = in_phi_angle;
  assign angle[1] = in_theta_angle;
  assign angle[2] = in_psi_angle;

  // sine and cosine pipeline for all three angles
  erpd_cordic #(
    .ANGLE_BITS (ANGLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_angle   (angle),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready),
    .trig_func  (trig_func),
    .trig       (trig)
  );

  // products, sums and saturation
  erpd_matrix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_matrix (
    .clk        (clk),
    .rst_n      (rst_n),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready),
    .trig_func  (trig_func),
    .trig       (trig),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_m      (m)
  );

  assign out_row0_col0 = m[0];
  assign out_row0_col1 = m[1];
  assign out_row0_col2 = m[2];
  assign out_row1_col0 = m[3];
  assign out_row1_col1 = m[4];
  assign out_row1_col2 = m[5];
  assign out_row2_col0 = m[6];
  assign out_row2_col1 = m[7];
  assign out_row2_col2 = m[8];

endmodule
